>>> sv/atts_pkg.sv
`timescale 1ns / 1ps

package atts_pkg;

   // field widths fixed by the interface
   localparam int MINUTE_W = 11;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   localparam int MAX_EVENTS_DEFAULT = 16;

   localparam logic [MINUTE_W-1:0] MINUTES_PER_DAY = MINUTE_W'(24 * 60);

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [MINUTE_W-1:0] span_start;
      logic [MINUTE_W-1:0] span_stop;
      logic                all_day;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic write_en;
      logic start;
      logic issue;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;
      logic last_issue;
   } status_type;

endpackage

>>> sv/atts_datapath.sv
`timescale 1ns / 1ps

module atts_datapath #(
   parameter int MAX_EVENTS = atts_pkg::MAX_EVENTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  atts_pkg::cmd_type            cmd,
   output atts_pkg::status_type         status,
   input  logic [atts_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [atts_pkg::MINUTE_W-1:0] req_start_minute,
   input  logic [atts_pkg::MINUTE_W-1:0] req_end_minute,
   input  logic                         req_all_day,
   input  logic [atts_pkg::MINUTE_W-1:0] req_query_minute,
   input  logic [atts_pkg::COUNT_W-1:0]  req_entry_count,
   output logic                         rsp_found,
   output logic [atts_pkg::INDEX_W-1:0]  rsp_target_index
);
   import atts_pkg::*;

   localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int CNT_W = $clog2(MAX_EVENTS + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [CMP_W-1:0] MaxCmp = CMP_W'(MAX_EVENTS);

   entry_type event_mem [MAX_EVENTS];

   entry_type             rd_data_ff;
   logic [CNT_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      limit_ff;
   logic [CMP_W-1:0]      limit_cmp;
   logic [MINUTE_W-1:0]   minute_ff;
   logic                  eval_valid_ff;
   logic [INDEX_W-1:0]    eval_idx_ff;
   logic                  have_in_ff;
   logic                  have_later_ff;
   logic [INDEX_W-1:0]    in_idx_ff;
   logic [INDEX_W-1:0]    later_idx_ff;
   logic                  found_ff;
   logic [INDEX_W-1:0]    target_ff;
   logic                  write_ok;
   logic                  hit_in;
   logic                  hit_later;

   // saturate the count to the table depth
   always_comb begin
      limit_cmp = CMP_W'(req_entry_count);
      if (limit_cmp > MaxCmp) begin
         limit_cmp = MaxCmp;
      end
   end

   assign write_ok = CMP_W'(req_entry_index) < MaxCmp;

   assign status.skip       = (req_query_minute >= MINUTES_PER_DAY) || (limit_cmp == '0);
   assign status.last_issue = rd_ptr_ff == (limit_ff - CNT_W'(1));

   assign hit_in = eval_valid_ff && !rd_data_ff.all_day && !have_in_ff
                   && (rd_data_ff.span_start <= minute_ff)
                   && (minute_ff < rd_data_ff.span_stop);
   assign hit_later = eval_valid_ff && !rd_data_ff.all_day && !have_later_ff
                      && (rd_data_ff.span_start > minute_ff);

   // table storage, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_en && write_ok) begin
         event_mem[IDX_W'(req_entry_index)] <= '{span_start: req_start_minute,
                                                span_stop:  req_end_minute,
                                                all_day:    req_all_day};
      end
      if (cmd.issue) begin
         rd_data_ff <= event_mem[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_valid_ff <= 1'b0;
      end else begin
         eval_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         minute_ff     <= req_query_minute;
         limit_ff      <= CNT_W'(limit_cmp);
         rd_ptr_ff     <= '0;
         have_in_ff    <= 1'b0;
         have_later_ff <= 1'b0;
         in_idx_ff     <= '0;
         later_idx_ff  <= '0;
      end else begin
         if (cmd.issue) begin
            rd_ptr_ff   <= rd_ptr_ff + CNT_W'(1);
            eval_idx_ff <= INDEX_W'(rd_ptr_ff);
         end
         if (hit_in) begin
            have_in_ff <= 1'b1;
            in_idx_ff  <= eval_idx_ff;
         end
         if (hit_later) begin
            have_later_ff <= 1'b1;
            later_idx_ff  <= eval_idx_ff;
         end
      end
   end

   // result register, containing entry wins over a later one
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         found_ff <= have_in_ff || have_later_ff;
         if (have_in_ff) begin
            target_ff <= in_idx_ff;
         end else if (have_later_ff) begin
            target_ff <= later_idx_ff;
         end else begin
            target_ff <= '0;
         end
      end
   end

   assign rsp_found        = found_ff;
   assign rsp_target_index = target_ff;

endmodule

>>> sv/atts_controller.sv
`timescale 1ns / 1ps

module atts_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output atts_pkg::cmd_type    cmd,
   input  atts_pkg::status_type status
);
   import atts_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign req_ready = state_ff == IDLE;
   assign accept    = req_valid && req_ready;

   assign cmd.write_en = accept && (req_type == REQ_WRITE);
   assign cmd.start    = accept && (req_type == REQ_QUERY);
   assign cmd.issue    = state_ff == SCAN;
   assign cmd.load_rsp = (state_ff == FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            if (cmd.start) begin
               state_in = status.skip ? FINISH : SCAN;
            end
         end
         SCAN: begin
            if (status.last_issue) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = FINISH;
         end
         FINISH: begin
            if (cmd.load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/agenda_time_target_search_top.sv
// agenda time target search: a table of up to MAX_EVENTS timed events (start minute,
// exclusive end minute, all-day flag) with a query that returns the first non-all-day
// entry whose span holds a given minute, or failing that the first one that starts
// later, or not found. A write transaction (req_type 0) stores one entry and gives
// no result; slots at or past MAX_EVENTS are dropped. A query transaction (req_type 1)
// gives exactly one result once the scan of n = min(entry_count, MAX_EVENTS) entries
// is done, or without a scan when n is zero or the minute is 1440 or more. The scan
// walks the event table through its single read port, one entry per cycle, both
// searches sharing that pass. The block takes one transaction at a time; a write may
// enter while the previous result still waits on rsp_ready. Entries must be written
// before a query reads them, the table is not cleared by reset.
`timescale 1ns / 1ps

module agenda_time_target_search_top #(
   parameter int MAX_EVENTS = atts_pkg::MAX_EVENTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [atts_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [atts_pkg::MINUTE_W-1:0] req_start_minute,
   input  logic [atts_pkg::MINUTE_W-1:0] req_end_minute,
   input  logic                          req_all_day,
   input  logic [atts_pkg::MINUTE_W-1:0] req_query_minute,
   input  logic [atts_pkg::COUNT_W-1:0]  req_entry_count,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [atts_pkg::INDEX_W-1:0]  rsp_target_index
);
   import atts_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: accepts transactions, walks the scan, hands off the result
   atts_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // event table, compare logic, running matches and the result register
   atts_datapath #(
      .MAX_EVENTS (MAX_EVENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_entry_index  (req_entry_index),
      .req_start_minute (req_start_minute),
      .req_end_minute   (req_end_minute),
      .req_all_day      (req_all_day),
      .req_query_minute (req_query_minute),
      .req_entry_count  (req_entry_count),
      .rsp_found        (rsp_found),
      .rsp_target_index (rsp_target_index)
   );

endmodule

>>> sv/atts_checker.sv
`timescale 1ns / 1ps

module atts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_type,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [atts_pkg::INDEX_W-1:0]  rsp_target_index
);
   import atts_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
                                  && $stable(rsp_target_index))
      else $error("rsp payload changed while stalled");

   // not found always carries index zero
   a_not_found_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_target_index == '0)
      else $error("not found with nonzero index");

   // a query keeps the block busy in the cycle after its acceptance
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_QUERY |=> !req_ready)
      else $error("ready after query acceptance");

   // a write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("result after write");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind agenda_time_target_search_top atts_checker u_atts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_type         (req_type),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found        (rsp_found),
   .rsp_target_index (rsp_target_index)
);
